>>> rtl/sha_pkg.sv
// Shared types, codes and constants for the SHA-256 stream hasher.
// Used by sha_ctrl, sha_dpath and the top level; depends on nothing.
package sha_pkg;

	localparam int unsigned WORDS = 8;
	localparam int unsigned WIN = 16;

	// Source of the byte shifted into the block buffer.
	localparam logic [1:0] SRC_MSG  = 2'd0;
	localparam logic [1:0] SRC_PAD  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN  = 2'd3;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;

	localparam logic [WORDS-1:0][31:0] IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	typedef struct packed {
		logic       shift;
		logic [1:0] src;
		logic       count;
		logic       load_v;
		logic       round;
		logic [5:0] rnd;
		logic       add;
		logic       reinit;
		logic [2:0] word;
	} sha_cmd_t;

	typedef struct packed {
		logic pos_end;
		logic pos_len;
	} sha_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/sha_ctrl.sv
// Controller state machine: input and output handshakes, padding sequence,
// round counting and digest word selection. Depends on sha_pkg.
module sha_ctrl import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_stall,
	input  logic      has_byte,
	input  logic      last,
	output logic      dig_valid,
	input  logic      dig_stall,
	output logic [2:0] word_index,
	output logic      last_word,
	output sha_cmd_t  cmd,
	input  sha_stat_t stat
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PAD80  = 3'd1;
	localparam logic [2:0] S_PADZ   = 3'd2;
	localparam logic [2:0] S_PADLEN = 3'd3;
	localparam logic [2:0] S_COMP   = 3'd4;
	localparam logic [2:0] S_ADD    = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] ret_q, ret_d;
	logic [5:0] rnd_q;
	logic [2:0] word_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		ret_d = ret_q;
		msg_stall = 1'b1;
		dig_valid = 1'b0;
		cmd.rnd = rnd_q;
		cmd.word = word_q;
		unique case (state_q)
			S_IDLE: begin
				msg_stall = 1'b0;
				if (msg_valid) begin
					if (has_byte) begin
						cmd.shift = 1'b1;
						cmd.src = SRC_MSG;
						cmd.count = 1'b1;
					end
					// A byte that fills the block is compressed before padding starts.
					if (has_byte && stat.pos_end) begin
						cmd.load_v = 1'b1;
						state_d = S_COMP;
						ret_d = last ? S_PAD80 : S_IDLE;
					end else if (last) begin
						state_d = S_PAD80;
					end
				end
			end
			S_PAD80: begin
				cmd.shift = 1'b1;
				cmd.src = SRC_PAD;
				if (stat.pos_end) begin
					cmd.load_v = 1'b1;
					state_d = S_COMP;
					ret_d = S_PADZ;
				end else begin
					state_d = S_PADZ;
				end
			end
			S_PADZ: begin
				if (stat.pos_len) begin
					state_d = S_PADLEN;
				end else begin
					cmd.shift = 1'b1;
					cmd.src = SRC_ZERO;
					if (stat.pos_end) begin
						cmd.load_v = 1'b1;
						state_d = S_COMP;
						ret_d = S_PADZ;
					end
				end
			end
			S_PADLEN: begin
				cmd.shift = 1'b1;
				cmd.src = SRC_LEN;
				if (stat.pos_end) begin
					cmd.load_v = 1'b1;
					state_d = S_COMP;
					ret_d = S_OUT;
				end
			end
			S_COMP: begin
				cmd.round = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = ret_q;
			end
			S_OUT: begin
				dig_valid = 1'b1;
				if (!dig_stall && word_q == LAST_WORD) begin
					cmd.reinit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			rnd_q <= '0;
			word_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (cmd.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (dig_valid && !dig_stall) begin
				word_q <= word_q + 3'd1;
			end
		end
	end

	assign word_index = word_q;
	assign last_word = (word_q == LAST_WORD);

	a_last_round_adds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP && rnd_q == LAST_ROUND) |=> (state_q == S_ADD))
		else $error("compression did not end in the chaining add");

	a_out_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("input taken while digest is being sent");

	a_no_shift_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> !cmd.shift)
		else $error("block buffer written during compression");

	a_final_word_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_stall && last_word) |=> (state_q == S_IDLE && word_q == 3'd0))
		else $error("digest end did not return to idle");

	a_rounds_start_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_COMP) |-> (rnd_q == 6'd0))
		else $error("round counter out of step");

endmodule

>>> rtl/sha_dpath.sv
// Datapath: block buffer and message schedule window, byte count, working
// variables, round unit and chaining words. Depends on sha_pkg.
module sha_dpath import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  sha_cmd_t    cmd,
	output sha_stat_t   stat,
	output logic [31:0] digest_word
);

	// The buffer doubles as the schedule window: bytes shift in at the bottom,
	// and during rounds word t sits in the top entry.
	logic [WIN-1:0][31:0] w_q;
	logic [WORDS-1:0][31:0] v_q;
	logic [WORDS-1:0][31:0] h_q;
	logic [60:0] count_q;
	logic [5:0] pos_q;

	logic [63:0] bit_len;
	logic [7:0] byte_in;
	logic [WIN*32+7:0] w_shift;
	logic [31:0] w_next;
	logic [31:0] t1, t2, ch, maj;
	logic [31:0] a, e;

	assign bit_len = {count_q, 3'b000};

	always_comb begin
		unique case (cmd.src)
			SRC_MSG:  byte_in = data_byte;
			SRC_PAD:  byte_in = PAD_BYTE;
			SRC_ZERO: byte_in = 8'h00;
			SRC_LEN:  byte_in = bit_len[{~pos_q[2:0], 3'b000} +: 8];
			default:  byte_in = 8'h00;
		endcase
	end

	assign w_shift = {w_q, byte_in};

	assign w_next = small_sigma1(w_q[1]) + w_q[6] + small_sigma0(w_q[14]) + w_q[15];

	assign a = v_q[0];
	assign e = v_q[4];
	assign ch = (e & v_q[5]) ^ (~e & v_q[6]);
	assign maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big_sigma1(e) + ch + round_k(cmd.rnd) + w_q[15];
	assign t2 = big_sigma0(a) + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			w_q <= w_shift[WIN*32-1:0];
		end else if (cmd.round) begin
			w_q <= {w_q[WIN-2:0], w_next};
		end
		if (cmd.load_v) begin
			v_q <= h_q;
		end else if (cmd.round) begin
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= IV;
			count_q <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.shift) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.reinit) begin
				h_q <= IV;
				count_q <= '0;
			end else begin
				if (cmd.count) begin
					count_q <= count_q + 61'd1;
				end
				if (cmd.add) begin
					for (int i = 0; i < WORDS; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
			end
		end
	end

	assign stat.pos_end = (pos_q == LAST_POS);
	assign stat.pos_len = (pos_q == LEN_POS);
	assign digest_word = h_q[cmd.word];

endmodule

>>> rtl/sha256_stream_hash.sv
// Top level of the SHA-256 stream hasher: joins sha_ctrl and sha_dpath.
// Depends on sha_pkg, sha_ctrl and sha_dpath.
//
// The block takes one message byte per beat and returns the 32-byte digest
// as eight big-endian words, first word first, after a beat marked last
// (which may carry no byte, so the empty message can be hashed). The beat
// that completes a 64-byte block then holds the input while the single
// round unit runs 64 rounds and the chaining add. After the last beat the
// padding bytes (up to 64, or 72 when an extra block is needed) are shifted
// in one per cycle, save while a filled block is compressed and at the step
// into the length bytes; each filled block is compressed in turn, and then
// the eight digest words are offered one per cycle as the output side takes
// them.
// No input is taken from the last beat until the eighth word is delivered.
module sha256_stream_hash import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_cmd_t cmd;
	sha_stat_t stat;

	sha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.has_byte   (has_byte),
		.last       (last),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.word_index (word_index),
		.last_word  (last_word),
		.cmd        (cmd),
		.stat       (stat)
	);

	sha_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (digest_word)
	);

endmodule

>>> sim/tb.sv
// Testbench for sha256_stream_hash: drives message bytes, predicts each SHA-256 digest
// with its own compression model, and checks every digest word as it arrives.
// Depends only on the RTL of sha256_stream_hash and its package.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 410;
	localparam int PHASE_BEATS = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int LEN_OFFSET = 56;
	localparam int DIGEST_WORDS = 8;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_CHAIN [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Message lengths around the block and padding boundaries.
	localparam int EDGE_LEN [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last_flag;
	} digest_entry_t;

	class digest_board;
		logic [31:0] chain [8];
		logic [60:0] nbytes;
		logic [7:0]  blk [64];
		digest_entry_t expected_words [$];
		int mismatches;

		function new();
			chain = INIT_CHAIN;
			nbytes = '0;
			mismatches = 0;
			foreach (blk[i]) blk[i] = 8'h00;
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] t1, t2, s0, s1;
			int i;
			for (i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			v = chain;
			for (i = 0; i < 64; i++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		// Takes one accepted input beat; a closing beat queues the eight digest words.
		function void absorb(logic [7:0] b, logic hb, logic lst);
			logic [63:0] bit_len;
			digest_entry_t e;
			int pos;
			int i;
			if (hb) begin
				blk[nbytes[5:0]] = b;
				nbytes = nbytes + 61'd1;
				if (nbytes[5:0] == 6'd0)
					compress();
			end
			if (!lst)
				return;
			bit_len = {nbytes, 3'b000};
			pos = int'(nbytes[5:0]);
			blk[pos] = PAD_MARK;
			pos++;
			// Not enough room left for the length field: spill into an extra block.
			if (pos > LEN_OFFSET) begin
				for (i = pos; i < 64; i++)
					blk[i] = 8'h00;
				compress();
				pos = 0;
			end
			for (i = pos; i < LEN_OFFSET; i++)
				blk[i] = 8'h00;
			for (i = 0; i < 8; i++)
				blk[LEN_OFFSET + i] = bit_len[8*(7-i) +: 8];
			compress();
			for (i = 0; i < DIGEST_WORDS; i++) begin
				e.word = chain[i];
				e.index = 3'(i);
				e.last_flag = (i == DIGEST_WORDS - 1);
				expected_words.push_back(e);
			end
			chain = INIT_CHAIN;
			nbytes = '0;
		endfunction

		function void compare_word(logic [31:0] w, logic [2:0] idx, logic lw);
			digest_entry_t e;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: unexpected digest word %h index %0d last %b",
						w, idx, lw);
				return;
			end
			e = expected_words.pop_front();
			if (w !== e.word || idx !== e.index || lw !== e.last_flag) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
						e.word, e.index, e.last_flag, w, idx, lw);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        last = 1'b0;
	logic        dig_valid;
	logic        dig_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int send_idle = 26;
	int recv_idle = 52;
	int beats_sent = 0;
	int items_sent = 0;
	int cycle_count = 0;
	digest_board board = new();

	sha256_stream_hash u_top (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.last(last),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		dig_stall <= ($urandom_range(99) < recv_idle);
		if (arst_n && dig_valid && !dig_stall)
			board.compare_word(digest_word, word_index, last_word);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: errors");
		$finish;
	end

	task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
		if (beats_sent < PHASE_BEATS) begin
			send_idle = 26;
			recv_idle = 52;
		end else if (beats_sent < 2 * PHASE_BEATS) begin
			send_idle = 52;
			recv_idle = 26;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			msg_valid <= 1'b0;
			data_byte <= 8'($urandom);
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		last <= lst;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		board.absorb(b, hb, lst);
		beats_sent++;
		if (hb || lst)
			items_sent++;
	endtask

	// A message of len bytes; with bare_end the closing beat carries no byte.
	task automatic send_message(input int len, input bit bare_end);
		int i;
		if (len == 0)
			bare_end = 1'b1;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom_range(255)), 1'b1, !bare_end && (i == len - 1));
		end
		if (bare_end)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int len;
		int random_start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, then a beat that carries nothing and must be ignored.
		send_beat(8'hff, 1'b0, 1'b1);
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		// "abc" closed by a beat without a byte.
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h7f, 1'b1, 1'b0);
		send_beat(8'h55, 1'b1, 1'b0);
		send_beat(8'haa, 1'b1, 1'b1);
		send_beat(8'h80, 1'b1, 1'b1);

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if ($urandom_range(1) == 0)
				len = EDGE_LEN[$urandom_range(9)];
			else
				len = $urandom_range(40, 1);
			send_message(len, $urandom_range(3) == 0);
		end
		msg_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

>>> files.f
rtl/sha_pkg.sv
rtl/sha_ctrl.sv
rtl/sha_dpath.sv
rtl/sha256_stream_hash.sv
sim/tb.sv
